// ===== rtl/apeq_pkg.sv =====
`default_nettype none

package apeq_pkg;

   localparam int DIGIT_WIDTH = 24;
   localparam int STEP_W = 4;
   localparam int CSR_INDEX_W = 2;

   typedef logic [STEP_W-1:0] step_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_ALLPASS_COEF   = 2'd0;
   localparam csr_index_type CSR_CENTER_COEF    = 2'd1;
   localparam csr_index_type CSR_GAIN_MINUS_ONE = 2'd2;

   localparam step_type ST_IDLE    = 4'd0;
   localparam step_type ST_MUL_E   = 4'd1;
   localparam step_type ST_WAIT_E  = 4'd2;
   localparam step_type ST_MUL_P1  = 4'd3;
   localparam step_type ST_WAIT_P1 = 4'd4;
   localparam step_type ST_MUL_P2  = 4'd5;
   localparam step_type ST_WAIT_P2 = 4'd6;
   localparam step_type ST_MUL_CW  = 4'd7;
   localparam step_type ST_WAIT_CW = 4'd8;
   localparam step_type ST_MUL_T   = 4'd9;
   localparam step_type ST_WAIT_T  = 4'd10;
   localparam step_type ST_EMIT    = 4'd11;

   typedef enum logic [1:0] {
      JC_NEVER,
      JC_NO_REQ,
      JC_MUL_WAIT,
      JC_RSP_FULL
   } jump_cond_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_LOAD_X,
      ACT_SAVE_P1,
      ACT_SAVE_W,
      ACT_EMIT
   } action_type;

   typedef enum logic [1:0] {
      A_D,
      A_E,
      A_C,
      A_H
   } a_sel_type;

   typedef enum logic [2:0] {
      B_ONEC,
      B_S1,
      B_S2,
      B_W,
      B_DIFF
   } b_sel_type;

   typedef struct packed {
      jump_cond_type cond;
      step_type      target;
      logic          last;
      logic          mul_start;
      a_sel_type     a_sel;
      b_sel_type     b_sel;
      logic          rnd_half;
      action_type    action;
   } uword_type;

   typedef struct packed {
      logic start;
      logic rnd_half;
   } mul_ctl_type;

   function automatic uword_type apeq_ucode(input step_type step);
      uword_type uw;
      uw = '0;
      uw.cond = JC_NEVER;
      uw.target = ST_IDLE;
      uw.a_sel = A_D;
      uw.b_sel = B_ONEC;
      uw.action = ACT_NONE;
      case (step)
         ST_IDLE: begin
            uw.cond = JC_NO_REQ;
            uw.target = ST_IDLE;
            uw.action = ACT_LOAD_X;
         end
         ST_MUL_E: begin
            uw.mul_start = 1'b1;
            uw.a_sel = A_D;
            uw.b_sel = B_ONEC;
         end
         ST_WAIT_E: begin
            uw.cond = JC_MUL_WAIT;
            uw.target = ST_WAIT_E;
         end
         ST_MUL_P1: begin
            uw.mul_start = 1'b1;
            uw.a_sel = A_E;
            uw.b_sel = B_S1;
         end
         ST_WAIT_P1: begin
            uw.cond = JC_MUL_WAIT;
            uw.target = ST_WAIT_P1;
         end
         ST_MUL_P2: begin
            uw.action = ACT_SAVE_P1;
            uw.mul_start = 1'b1;
            uw.a_sel = A_C;
            uw.b_sel = B_S2;
         end
         ST_WAIT_P2: begin
            uw.cond = JC_MUL_WAIT;
            uw.target = ST_WAIT_P2;
         end
         ST_MUL_CW: begin
            uw.action = ACT_SAVE_W;
            uw.mul_start = 1'b1;
            uw.a_sel = A_C;
            uw.b_sel = B_W;
         end
         ST_WAIT_CW: begin
            uw.cond = JC_MUL_WAIT;
            uw.target = ST_WAIT_CW;
         end
         ST_MUL_T: begin
            uw.mul_start = 1'b1;
            uw.a_sel = A_H;
            uw.b_sel = B_DIFF;
            uw.rnd_half = 1'b1;
         end
         ST_WAIT_T: begin
            uw.cond = JC_MUL_WAIT;
            uw.target = ST_WAIT_T;
         end
         ST_EMIT: begin
            uw.cond = JC_RSP_FULL;
            uw.target = ST_EMIT;
            uw.action = ACT_EMIT;
            uw.last = 1'b1;
         end
         default: begin
            uw.last = 1'b1;
         end
      endcase
      return uw;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/apeq_req_if.sv =====
`default_nettype none

interface apeq_req_if #(
   parameter int SAMPLE_WIDTH = 24
) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

// ===== rtl/apeq_rsp_if.sv =====
`default_nettype none

interface apeq_rsp_if #(
   parameter int SAMPLE_WIDTH = 24
) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_out;
   logic                           clipped;

   modport source (output valid, output sample_out, output clipped, input ready);
   modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

`default_nettype wire

// ===== rtl/apeq_mul.sv =====
`default_nettype none

module apeq_mul
   import apeq_pkg::*;
#(
   parameter int A_WIDTH   = 28,
   parameter int B_WIDTH   = 36,
   parameter int RES_WIDTH = 41,
   parameter int FRAC_BITS = 22
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire mul_ctl_type                   ctl,
   input  wire logic signed [A_WIDTH-1:0]     a,
   input  wire logic signed [B_WIDTH-1:0]     b,
   output logic                               done,
   output logic signed [RES_WIDTH-1:0]        res
);

   localparam int ND   = (B_WIDTH + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
   localparam int BP   = ND * DIGIT_WIDTH;
   localparam int PW   = A_WIDTH + BP;
   localparam int PPW  = A_WIDTH + DIGIT_WIDTH + 1;
   localparam int CNTW = $clog2(ND + 2);

   localparam logic signed [PW-1:0] HALF_F  = PW'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [PW-1:0] HALF_F1 = PW'(1) <<< FRAC_BITS;

   logic                    busy_ff;
   logic [CNTW-1:0]         cnt_ff;
   logic signed [A_WIDTH-1:0] a_ff;
   logic signed [BP-1:0]    b_ff;
   logic signed [PPW-1:0]   pp_ff;
   logic signed [PW-1:0]    acc_ff;
   logic signed [RES_WIDTH-1:0] res_ff;
   logic                    rnd_ff;

   logic                    issue;
   logic                    accum;
   logic                    last;
   logic [DIGIT_WIDTH-1:0]  top_digit;
   logic signed [DIGIT_WIDTH:0] digit_s;
   logic signed [PW-1:0]    rnd_add;
   logic signed [PW-1:0]    neg_ext;
   logic signed [PW-1:0]    sum_r;
   logic signed [PW-1:0]    shifted;

   always_comb begin
      issue = (cnt_ff < CNTW'(ND));
      accum = (cnt_ff != '0) && (cnt_ff <= CNTW'(ND));
      last = (cnt_ff == CNTW'(ND + 1));
      top_digit = b_ff[BP-1 -: DIGIT_WIDTH];
      digit_s = {(cnt_ff == '0) ? top_digit[DIGIT_WIDTH-1] : 1'b0, top_digit};
      rnd_add = rnd_ff ? HALF_F1 : HALF_F;
      neg_ext = {{(PW-1){1'b0}}, acc_ff[PW-1]};
      sum_r = acc_ff + rnd_add - neg_ext;
      shifted = rnd_ff ? (sum_r >>> (FRAC_BITS + 1)) : (sum_r >>> FRAC_BITS);
      done = busy_ff && last;
      res = res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (ctl.start) begin
         busy_ff <= 1'b1;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + CNTW'(1);
         if (last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         a_ff <= a;
         b_ff <= BP'(b);
         acc_ff <= '0;
         rnd_ff <= ctl.rnd_half;
      end else if (busy_ff) begin
         if (issue) begin
            pp_ff <= a_ff * digit_s;
            b_ff <= b_ff << DIGIT_WIDTH;
         end
         if (accum) begin
            acc_ff <= (acc_ff <<< DIGIT_WIDTH) + PW'(pp_ff);
         end
         if (last) begin
            res_ff <= RES_WIDTH'(shifted);
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/allpass_peak_eq_filter.sv =====
`default_nettype none

// Peak (bell) equalizer on a second-order allpass section, one signed Q1.(SAMPLE_WIDTH-1)
// sample per item and one saturated sample per result, with clipped set when the output or
// the new allpass state saturated. Coefficients c, d (Q2.F) and h0 (Q6.F) are written through
// the csr port and all reset to zero, and so does the filter state; they must be written only
// while the block is idle, which the block itself does not enforce. The five products of each
// item run one after another in a single shared multiplier that takes one 24-bit digit of
// its second operand per cycle, under a small microcode program; the widest second operand
// is max(SAMPLE_WIDTH+12, COEF_FRAC_BITS+3) bits. The next item is accepted as soon as the
// result is in the output register, even while it still waits to be taken.
module allpass_peak_eq_filter
   import apeq_pkg::*;
#(
   parameter int SAMPLE_WIDTH   = 24,
   parameter int COEF_FRAC_BITS = 22
) (
   input  wire                               clock,
   input  wire                               reset,
   apeq_req_if.sink                          req_chan,
   apeq_rsp_if.source                        rsp_chan,
   input  wire                               csr_we,
   input  wire csr_index_type                csr_index,
   input  wire logic [COEF_FRAC_BITS+5:0]    csr_wdata
);

   localparam int SW  = SAMPLE_WIDTH;
   localparam int F   = COEF_FRAC_BITS;
   localparam int STW = SW + 8;
   localparam int CW  = F + 2;
   localparam int HW  = F + 6;
   localparam int OCW = F + 3;
   localparam int EW  = F + 4;
   localparam int P1W = SW + 11;
   localparam int DW  = SW + 12;
   localparam int TW  = SW + 17;
   localparam int YW  = SW + 18;
   localparam int AW  = HW;
   localparam int BW  = (DW > OCW) ? DW : OCW;
   localparam int RW  = (TW > EW) ? TW : EW;

   localparam logic signed [OCW-1:0] ONE_Q  = OCW'(64'sd1 <<< F);
   localparam logic signed [STW-1:0] ST_MAX = {1'b0, {(STW-1){1'b1}}};
   localparam logic signed [STW-1:0] ST_MIN = {1'b1, {(STW-1){1'b0}}};
   localparam logic signed [SW-1:0]  Y_MAX  = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0]  Y_MIN  = {1'b1, {(SW-1){1'b0}}};

   step_type                step_ff;
   step_type                step_in;
   uword_type               uw;
   logic                    jump;
   logic                    go;

   logic signed [CW-1:0]    c_ff;
   logic signed [CW-1:0]    d_ff;
   logic signed [HW-1:0]    h0_ff;
   logic signed [STW-1:0]   s1_ff;
   logic signed [STW-1:0]   s2_ff;
   logic signed [SW-1:0]    x_ff;
   logic signed [P1W-1:0]   p1_ff;
   logic signed [STW-1:0]   w_ff;
   logic                    clip_ff;
   logic                    rsp_valid_ff;
   logic signed [SW-1:0]    out_ff;
   logic                    out_clip_ff;

   mul_ctl_type             mul_ctl;
   logic signed [AW-1:0]    mul_a;
   logic signed [BW-1:0]    mul_b;
   logic                    mul_done;
   logic signed [RW-1:0]    mul_res;

   logic signed [OCW-1:0]   onec;
   logic signed [DW-1:0]    sum_w;
   logic [DW-STW:0]         w_hi;
   logic                    w_ovf;
   logic signed [STW-1:0]   w_in;
   logic signed [DW-1:0]    diff_in;
   logic signed [YW-1:0]    sum_y;
   logic [YW-SW:0]          y_hi;
   logic                    y_ovf;
   logic signed [SW-1:0]    y_sat;

   apeq_mul #(
      .A_WIDTH(AW),
      .B_WIDTH(BW),
      .RES_WIDTH(RW),
      .FRAC_BITS(F)
   ) u_apeq_mul (
      .clock(clock),
      .reset(reset),
      .ctl(mul_ctl),
      .a(mul_a),
      .b(mul_b),
      .done(mul_done),
      .res(mul_res)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      uw = apeq_ucode(step_ff);
      case (uw.cond)
         JC_NEVER:    jump = 1'b0;
         JC_NO_REQ:   jump = !req_chan.valid;
         JC_MUL_WAIT: jump = !mul_done;
         JC_RSP_FULL: jump = rsp_valid_ff && !rsp_chan.ready;
         default:     jump = 1'b0;
      endcase
      go = !jump;
      if (jump) begin
         step_in = uw.target;
      end else if (uw.last) begin
         step_in = ST_IDLE;
      end else begin
         step_in = step_ff + STEP_W'(1);
      end
      req_chan.ready = (uw.action == ACT_LOAD_X);
      mul_ctl.start = uw.mul_start && go;
      mul_ctl.rnd_half = uw.rnd_half;
   end

   // datapath
   always_comb begin
      onec = ONE_Q - OCW'(c_ff);

      sum_w = DW'(x_ff) - DW'(p1_ff) + DW'(mul_res);
      w_hi = sum_w[DW-1:STW-1];
      w_ovf = !((&w_hi) || !(|w_hi));
      w_in = w_ovf ? (sum_w[DW-1] ? ST_MIN : ST_MAX) : sum_w[STW-1:0];

      diff_in = DW'(x_ff) + DW'(mul_res) - DW'(p1_ff) - DW'(s2_ff);

      sum_y = YW'(x_ff) + YW'(mul_res);
      y_hi = sum_y[YW-1:SW-1];
      y_ovf = !((&y_hi) || !(|y_hi));
      y_sat = y_ovf ? (sum_y[YW-1] ? Y_MIN : Y_MAX) : sum_y[SW-1:0];

      case (uw.a_sel)
         A_D:     mul_a = AW'(d_ff);
         A_E:     mul_a = AW'(mul_res);
         A_C:     mul_a = AW'(c_ff);
         A_H:     mul_a = h0_ff;
         default: mul_a = '0;
      endcase

      case (uw.b_sel)
         B_ONEC:  mul_b = BW'(onec);
         B_S1:    mul_b = BW'(s1_ff);
         B_S2:    mul_b = BW'(s2_ff);
         B_W:     mul_b = BW'(w_in);
         B_DIFF:  mul_b = BW'(diff_in);
         default: mul_b = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff <= '0;
         d_ff <= '0;
         h0_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ALLPASS_COEF:   c_ff <= csr_wdata[CW-1:0];
            CSR_CENTER_COEF:    d_ff <= csr_wdata[CW-1:0];
            CSR_GAIN_MINUS_ONE: h0_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (go && uw.action == ACT_EMIT) begin
            rsp_valid_ff <= 1'b1;
            s2_ff <= s1_ff;
            s1_ff <= w_ff;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         case (uw.action)
            ACT_LOAD_X:    x_ff <= req_chan.sample_in;
            ACT_SAVE_P1:   p1_ff <= P1W'(mul_res);
            ACT_SAVE_W: begin
               w_ff <= w_in;
               clip_ff <= w_ovf;
            end
            ACT_EMIT: begin
               out_ff <= y_sat;
               out_clip_ff <= clip_ff || y_ovf;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.sample_out = out_ff;
   assign rsp_chan.clipped = out_clip_ff;

endmodule

`default_nettype wire

// ===== rtl/apeq_checker.sv =====
`default_nettype none

module apeq_checker #(
   parameter int SAMPLE_WIDTH = 24
) (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_valid,
   input wire                              req_ready,
   input wire                              rsp_valid,
   input wire                              rsp_ready,
   input wire logic [SAMPLE_WIDTH-1:0]     sample_out,
   input wire                              clipped
);

   logic       req_fire;
   logic       rsp_fire;
   logic [1:0] outstanding_ff;
   logic [1:0] outstanding_in;

   always_comb begin
      req_fire = req_valid && req_ready;
      rsp_fire = rsp_valid && rsp_ready;
      outstanding_in = outstanding_ff + {1'b0, req_fire} - {1'b0, rsp_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(sample_out) && $stable(clipped))
      else $error("stalled result changed");

   a_no_extra_result: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> outstanding_ff != 2'd0)
      else $error("result without an item");

   a_outstanding_bound: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff != 2'd3)
      else $error("too many items in flight");

   a_one_item_per_pass: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_fire)
      else $error("item accepted while busy");

endmodule

bind allpass_peak_eq_filter apeq_checker #(
   .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_apeq_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .sample_out(rsp_chan.sample_out),
   .clipped(rsp_chan.clipped)
);

`default_nettype wire
